// ===== design/rmsr_pkg.sv =====
// Package: shared constants and types for the requantize multiply-shift-round core.
`timescale 1ns / 1ps

package rmsr_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_QUANT_MODE = 2'd0;
    localparam logic [1:0] REG_RND_MODE   = 2'd1;

    // Quantization modes
    localparam logic [1:0] QM_MUL_SHIFT  = 2'd0;
    localparam logic [1:0] QM_SHIFT_ONLY = 2'd1;
    localparam logic [1:0] QM_QMULT      = 2'd2;

    // Rounding modes
    localparam logic [2:0] RM_HALF_EVEN = 3'd0;
    localparam logic [2:0] RM_HALF_AWAY = 3'd1;
    localparam logic [2:0] RM_TO_ZERO   = 3'd2;
    localparam logic [2:0] RM_DOWN      = 3'd3;
    localparam logic [2:0] RM_UP        = 3'd4;
    localparam logic [2:0] RM_HALF_UP   = 3'd5;
    localparam logic [2:0] RM_HALF_DOWN = 3'd6;

    // Fixed-point scale and saturation limits for the quantized multiplier
    localparam int unsigned SCALE_SHIFT = 31;
    localparam logic [5:0]  MAX_RSHIFT  = 6'd63;
    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    // Final shift control carried down the pipeline
    typedef struct packed {
        logic       zero_out;
        logic       left;
        logic       right;
        logic [5:0] amt;
    } shift_ctl_t;

endpackage

// ===== design/requant_multiply_shift_round_core.sv =====
// Top level: five-stage requantizer (pre-shift, multiply, scale round, shift round, add).
`timescale 1ns / 1ps
// An accepted beat moves through the stage 1-4 registers, then result_reg.
// Throughput: one beat per cycle when not stalled; the 32x32 multiply
// and the barrel shift each take one stage, and the pipeline never iterates.
// An output stall holds every full stage in the same cycle; bubbles still fill.
// Reset (rst_n low, async) clears all stage valid bits and both mode registers.

module requant_multiply_shift_round_core
    import rmsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] acc_value,
    input  logic signed [31:0] scale_mult,
    input  logic signed [6:0]  shift_amount,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] requant_result
);

    // Configuration registers
    logic [1:0] quant_mode_reg;
    logic [2:0] rnd_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_mode_reg <= QM_MUL_SHIFT;
            rnd_mode_reg   <= RM_HALF_EVEN;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_QUANT_MODE: quant_mode_reg <= cfg_data[1:0];
                REG_RND_MODE:   rnd_mode_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               out_valid_reg;
    logic signed [31:0] s1_a_reg, s1_b_reg;
    shift_ctl_t         s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic signed [63:0] s2_prod_reg;
    logic [63:0]        s3_value_reg;
    logic [63:0]        s4_val_reg;
    logic               s4_inc_reg;
    logic [63:0]        result_reg;

    // Stage ready chain
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    assign s5_ready = !out_valid_reg || !out_stall;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg  <= in_valid;
            if (s2_ready) s2_valid_reg  <= s1_valid_reg;
            if (s3_ready) s3_valid_reg  <= s2_valid_reg;
            if (s4_ready) s4_valid_reg  <= s3_valid_reg;
            if (s5_ready) out_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1: mode 2 left pre-shift, multiplier operands, final shift decode
    logic signed [31:0] s1_a_next, s1_b_next;
    logic [31:0]        pre_shifted;
    logic [6:0]         neg_mag;
    logic               sh_pos;
    shift_ctl_t         s1_ctl_next;

    always_comb
    begin
        neg_mag     = 7'(-shift_amount);
        sh_pos      = !shift_amount[6] && (shift_amount != 7'sd0);
        // shift of 32 or more clears the value
        pre_shifted = shift_amount[5] ? 32'd0 : (acc_value << shift_amount[4:0]);
        s1_a_next   = (quant_mode_reg == QM_QMULT && sh_pos) ? pre_shifted : acc_value;
        s1_b_next   = (quant_mode_reg == QM_SHIFT_ONLY) ? 32'sd1 : scale_mult;

        s1_ctl_next = '0;
        unique case (quant_mode_reg) inside
            QM_MUL_SHIFT, QM_SHIFT_ONLY:
            begin
                if (sh_pos)
                begin
                    s1_ctl_next.right = 1'b1;
                    s1_ctl_next.amt   = shift_amount[5:0];
                end
                else if (shift_amount[6])
                begin
                    // left by 64 gives zero
                    if (neg_mag[6])
                        s1_ctl_next.zero_out = 1'b1;
                    else
                    begin
                        s1_ctl_next.left = 1'b1;
                        s1_ctl_next.amt  = neg_mag[5:0];
                    end
                end
            end
            QM_QMULT:
            begin
                if (shift_amount[6])
                begin
                    s1_ctl_next.right = 1'b1;
                    s1_ctl_next.amt   = neg_mag[6] ? MAX_RSHIFT : neg_mag[5:0];
                end
            end
            default: s1_ctl_next.zero_out = 1'b1;
        endcase
    end

    // Stage 2: signed 32x32 multiply
    logic signed [63:0] s2_prod_next;

    assign s2_prod_next = s1_a_reg * s1_b_reg;

    // Stage 3: mode 2 half-up shift by 31 and saturation to 32 bits
    logic signed [33:0] scaled;
    logic signed [31:0] saturated;
    logic [63:0]        s3_value_next;

    always_comb
    begin
        scaled = $signed({s2_prod_reg[63], s2_prod_reg[63:SCALE_SHIFT]})
               + $signed({33'd0, s2_prod_reg[SCALE_SHIFT-1]});
        if (scaled > SAT_MAX)
            saturated = SAT_MAX[31:0];
        else if (scaled < SAT_MIN)
            saturated = SAT_MIN[31:0];
        else
            saturated = scaled[31:0];

        if (quant_mode_reg == QM_QMULT)
            s3_value_next = 64'(saturated);
        else
            s3_value_next = s2_prod_reg;
    end

    // Stage 4: barrel shift and rounding decision
    logic [63:0] s4_val_next;
    logic        s4_inc_next;
    logic [63:0] low_mask;
    logic        round_bit, sticky, neg;

    always_comb
    begin
        neg         = s3_value_reg[63];
        low_mask    = (64'd1 << (s3_ctl_reg.amt - 6'd1)) - 64'd1;
        round_bit   = s3_value_reg[s3_ctl_reg.amt - 6'd1];
        sticky      = |(s3_value_reg & low_mask);
        s4_val_next = s3_value_reg;
        s4_inc_next = 1'b0;

        if (s3_ctl_reg.zero_out)
            s4_val_next = 64'd0;
        else if (s3_ctl_reg.left)
            s4_val_next = s3_value_reg << s3_ctl_reg.amt;
        else if (s3_ctl_reg.right)
        begin
            s4_val_next = 64'($signed(s3_value_reg) >>> s3_ctl_reg.amt);
            case (rnd_mode_reg)
                RM_HALF_EVEN: s4_inc_next = round_bit && (sticky || s4_val_next[0]);
                RM_HALF_AWAY: s4_inc_next = neg ? (round_bit && sticky) : round_bit;
                RM_TO_ZERO:   s4_inc_next = neg && (round_bit || sticky);
                RM_UP:        s4_inc_next = round_bit || sticky;
                RM_HALF_UP:   s4_inc_next = round_bit;
                RM_HALF_DOWN: s4_inc_next = round_bit && sticky;
                default:      s4_inc_next = 1'b0;   // floor, and the unused code
            endcase
        end
    end

    // Stage 5: apply the rounding increment
    logic [63:0] result_next;

    assign result_next = s4_val_reg + {63'd0, s4_inc_reg};

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_a_reg   <= s1_a_next;
            s1_b_reg   <= s1_b_next;
            s1_ctl_reg <= s1_ctl_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_ctl_reg  <= s1_ctl_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_value_reg <= s3_value_next;
            s3_ctl_reg   <= s2_ctl_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_val_reg <= s4_val_next;
            s4_inc_reg <= s4_inc_next;
        end
        if (s5_ready && s4_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign requant_result = result_reg;

    // Assertions
    // input backs up only when every stage holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                      && out_valid_reg))
        else $error("input stalled with an empty stage");

    // quantized multiplier results stay within signed 32 bits
    a_qmult_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && quant_mode_reg == QM_QMULT)
            |-> (requant_result[63:31] == '0 || requant_result[63:31] == '1))
        else $error("mode 2 result outside signed 32-bit range");

    // unused quant mode always yields zero
    a_mode3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && quant_mode_reg == 2'd3) |-> requant_result == 64'd0)
        else $error("unused quant mode gave nonzero result");

    // shift control is never both directions
    a_ctl_dir: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> !(s3_ctl_reg.left && s3_ctl_reg.right))
        else $error("shift control both left and right");

    // a waiting beat in stage 4 is kept while the output is blocked
    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !s5_ready) |=> (s4_valid_reg && $stable(s4_val_reg)))
        else $error("stage 4 beat lost under stall");

endmodule
